FILE: hdl/sps_pkg.sv
`default_nettype none

package sps_pkg;

  localparam int ROOT2_Q16 = 92682;
  localparam int FRAC_SHIFT = 16;
  localparam int DROP_BITS = 16;
  localparam logic [15:0] FULL_ALPHA = 16'hFFFF;

  localparam logic signed [31:0] CAMERA_X_RST = 32'sd0;
  localparam logic signed [31:0] CAMERA_Y_RST = -32'sd512000;
  localparam logic signed [31:0] CAMERA_Z_RST = 32'sd0;
  localparam logic [19:0] EXPOSURE_RST = 20'd50000;

  typedef enum logic [1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_EXPOSURE_GAIN
  } cfg_reg_t;

  typedef enum logic {
    ACT_SPLAT,
    ACT_READ
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_DIV_DROP,
    ST_RD,
    ST_WB,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    MOP_COL,
    MOP_ROW,
    MOP_COL_OFS,
    MOP_ROW_OFS,
    MOP_SQ_X,
    MOP_SQ_Y,
    MOP_SQ_Z,
    MOP_GAIN,
    MOP_ADDR
  } mul_op_t;

endpackage

`default_nettype wire

FILE: hdl/sps_in_if.sv
`default_nettype none

interface sps_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] star_x;
  logic signed [31:0] star_y;
  logic signed [31:0] star_z;
  logic [31:0]        luminance;
  logic [10:0]        read_col;
  logic [9:0]         read_row;

  modport source (
    output valid, action, star_x, star_y, star_z, luminance, read_col, read_row,
    input  ready
  );

  modport sink (
    input  valid, action, star_x, star_y, star_z, luminance, read_col, read_row,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/sps_out_if.sv
`default_nettype none

interface sps_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [10:0] pixel_col;
  logic [9:0]  pixel_row;
  logic [15:0] alpha_value;
  logic        overlap;

  modport source (
    output valid, hit, pixel_col, pixel_row, alpha_value, overlap,
    input  ready
  );

  modport sink (
    input  valid, hit, pixel_col, pixel_row, alpha_value, overlap,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/star_projection_splatter_unit.sv
`default_nettype none

// A star taken in ST_IDLE runs the projection, offset, distance and gain multiplies,
// the column, row and drop divides, the address multiply, store read and write-back;
// a read runs only the last three; a miss goes to ST_DONE, which waits for a free
// output. Ready is high only in ST_IDLE, so no beat is taken before the last is done.
// One 34x34 multiplier and one shift-subtract divider are shared. Reset (sync, high)
// restores camera and gain, then sweeps the alpha store to full, one pixel per cycle.

module star_projection_splatter_unit #(
  parameter int IMAGE_WIDTH  = 1280,
  parameter int IMAGE_HEIGHT = 720
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  sps_in_if.sink           stars,
  sps_out_if.source        results
);

  localparam int HALF_W = IMAGE_WIDTH / 2;
  localparam int HALF_H = IMAGE_HEIGHT / 2;
  localparam int KC     = sps_pkg::ROOT2_Q16 * HALF_W;
  localparam int KC_W   = $clog2(KC + 1);
  localparam int NUM_W  = KC_W + 35;
  localparam int CB     = $clog2(IMAGE_WIDTH);
  localparam int RB     = $clog2(IMAGE_HEIGHT);
  localparam int COL_W  = (CB > 11) ? CB : 11;
  localparam int ROW_W  = (RB > 10) ? RB : 10;
  localparam int PIX    = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = $clog2(PIX);
  localparam int Q2_W   = 66;
  localparam int NUMD_W = 68;
  localparam int DIV_W  = (NUM_W > 82) ? NUM_W : 82;
  localparam int QW     = sps_pkg::DROP_BITS + 1;
  localparam int CNT_W  = $clog2(QW);

  sps_pkg::state_t  state, state_next;
  sps_pkg::mul_op_t mop;

  logic signed [31:0] camera_x, camera_y, camera_z;
  logic [19:0]        exposure_gain;

  logic [ADDR_W-1:0] clr_addr;
  logic [CNT_W-1:0]  dcnt;
  logic              out_valid;

  logic signed [32:0] tx, ty, tz;
  logic signed [32:0] tx_in, ty_in, tz_in;
  logic [31:0]        lum;
  logic               act;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;

  logic signed [33:0]      mul_a, mul_b;
  logic signed [67:0]      prod;
  logic signed [NUM_W-1:0] ncol, nrow;
  logic [Q2_W-1:0]         q2;
  logic [NUMD_W-1:0]       num;

  logic [DIV_W-1:0] rem, dsor;
  logic [DIV_W:0]   diff;
  logic             div_ge;
  logic [QW-1:0]    quo, q_fin;
  logic [15:0]      drop;
  logic [ADDR_W-1:0] addr;

  logic        res_hit, res_ovl;
  logic [15:0] res_alpha;

  logic        o_hit, o_ovl;
  logic [10:0] o_col;
  logic [9:0]  o_row;
  logic [15:0] o_alpha;

  logic        accept, miss, rd_in_range, col_ok, row_ok, out_free, load_out;
  logic        ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0] ram_wdata, ram_rdata, new_alpha;

  assign accept = stars.valid && stars.ready;
  assign stars.ready = (state == sps_pkg::ST_IDLE);

  assign tx_in = 33'(stars.star_x) - 33'(camera_x);
  assign ty_in = 33'(stars.star_y) - 33'(camera_y);
  assign tz_in = 33'(stars.star_z) - 33'(camera_z);

  assign rd_in_range = (13'(stars.read_col) < 13'(IMAGE_WIDTH)) &&
                       (13'(stars.read_row) < 13'(IMAGE_HEIGHT));

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop)
      sps_pkg::MOP_COL: begin
        mul_a = 34'(tx) + 34'(tz);
        mul_b = 34'(KC);
      end
      sps_pkg::MOP_ROW: begin
        mul_a = 34'(tz) - 34'(tx);
        mul_b = 34'(KC);
      end
      sps_pkg::MOP_COL_OFS: begin
        mul_a = 34'(ty);
        mul_b = 34'(HALF_W);
      end
      sps_pkg::MOP_ROW_OFS: begin
        mul_a = 34'(ty);
        mul_b = 34'(HALF_H);
      end
      sps_pkg::MOP_SQ_X: begin
        mul_a = 34'(tx);
        mul_b = 34'(tx);
      end
      sps_pkg::MOP_SQ_Y: begin
        mul_a = 34'(ty);
        mul_b = 34'(ty);
      end
      sps_pkg::MOP_SQ_Z: begin
        mul_a = 34'(tz);
        mul_b = 34'(tz);
      end
      sps_pkg::MOP_GAIN: begin
        mul_a = 34'(lum);
        mul_b = 34'(exposure_gain);
      end
      sps_pkg::MOP_ADDR: begin
        mul_a = 34'(row);
        mul_b = 34'(IMAGE_WIDTH);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared restoring divider step
  assign diff   = {1'b0, rem} - {1'b0, dsor};
  assign div_ge = !diff[DIV_W];
  assign q_fin  = {quo[QW-2:0], div_ge};
  assign col_ok = !q_fin[CB] && ((CB + 1)'(q_fin[CB-1:0]) < (CB + 1)'(IMAGE_WIDTH));
  assign row_ok = !q_fin[RB] && ((RB + 1)'(q_fin[RB-1:0]) < (RB + 1)'(IMAGE_HEIGHT));

  assign new_alpha = (ram_rdata > drop) ? (ram_rdata - drop) : '0;
  assign out_free  = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    miss       = 1'b0;
    load_out   = 1'b0;
    case (state)
      sps_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(PIX - 1)) begin
          state_next = sps_pkg::ST_IDLE;
        end
      end
      sps_pkg::ST_IDLE: begin
        if (accept) begin
          if (stars.action == sps_pkg::ACT_READ) begin
            miss       = !rd_in_range;
            state_next = rd_in_range ? sps_pkg::ST_MUL : sps_pkg::ST_DONE;
          end else if (ty_in[32] || ty_in == '0) begin
            miss       = 1'b1;
            state_next = sps_pkg::ST_DONE;
          end else begin
            state_next = sps_pkg::ST_MUL;
          end
        end
      end
      sps_pkg::ST_MUL: begin
        state_next = sps_pkg::ST_ACC;
      end
      sps_pkg::ST_ACC: begin
        case (mop)
          sps_pkg::MOP_GAIN: begin
            if (ncol[NUM_W-1] || nrow[NUM_W-1]) begin
              miss       = 1'b1;
              state_next = sps_pkg::ST_DONE;
            end else begin
              state_next = sps_pkg::ST_DIV_COL;
            end
          end
          sps_pkg::MOP_ADDR: state_next = sps_pkg::ST_RD;
          default:           state_next = sps_pkg::ST_MUL;
        endcase
      end
      sps_pkg::ST_DIV_COL: begin
        if (dcnt == '0) begin
          miss       = !col_ok;
          state_next = col_ok ? sps_pkg::ST_DIV_ROW : sps_pkg::ST_DONE;
        end
      end
      sps_pkg::ST_DIV_ROW: begin
        if (dcnt == '0) begin
          miss       = !row_ok;
          state_next = row_ok ? sps_pkg::ST_DIV_DROP : sps_pkg::ST_DONE;
        end
      end
      sps_pkg::ST_DIV_DROP: begin
        if (dcnt == '0) begin
          state_next = sps_pkg::ST_MUL;
        end
      end
      sps_pkg::ST_RD: begin
        state_next = sps_pkg::ST_WB;
      end
      sps_pkg::ST_WB: begin
        state_next = sps_pkg::ST_DONE;
      end
      sps_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = sps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x      <= sps_pkg::CAMERA_X_RST;
      camera_y      <= sps_pkg::CAMERA_Y_RST;
      camera_z      <= sps_pkg::CAMERA_Z_RST;
      exposure_gain <= sps_pkg::EXPOSURE_RST;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      mop           <= sps_pkg::MOP_COL;
      dcnt          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sps_pkg::REG_CAMERA_X:      camera_x      <= cfg_data;
          sps_pkg::REG_CAMERA_Y:      camera_y      <= cfg_data;
          sps_pkg::REG_CAMERA_Z:      camera_z      <= cfg_data;
          sps_pkg::REG_EXPOSURE_GAIN: exposure_gain <= cfg_data[19:0];
          default: ;
        endcase
      end

      if (state == sps_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        sps_pkg::ST_IDLE: begin
          mop <= (stars.action == sps_pkg::ACT_READ) ? sps_pkg::MOP_ADDR : sps_pkg::MOP_COL;
        end
        sps_pkg::ST_ACC: begin
          case (mop)
            sps_pkg::MOP_COL:     mop <= sps_pkg::MOP_ROW;
            sps_pkg::MOP_ROW:     mop <= sps_pkg::MOP_COL_OFS;
            sps_pkg::MOP_COL_OFS: mop <= sps_pkg::MOP_ROW_OFS;
            sps_pkg::MOP_ROW_OFS: mop <= sps_pkg::MOP_SQ_X;
            sps_pkg::MOP_SQ_X:    mop <= sps_pkg::MOP_SQ_Y;
            sps_pkg::MOP_SQ_Y:    mop <= sps_pkg::MOP_SQ_Z;
            sps_pkg::MOP_SQ_Z:    mop <= sps_pkg::MOP_GAIN;
            sps_pkg::MOP_GAIN:    dcnt <= CNT_W'(CB);
            default: ;
          endcase
        end
        sps_pkg::ST_DIV_COL: begin
          dcnt <= (dcnt == '0) ? CNT_W'(RB) : dcnt - 1'b1;
        end
        sps_pkg::ST_DIV_ROW: begin
          dcnt <= (dcnt == '0) ? CNT_W'(sps_pkg::DROP_BITS) : dcnt - 1'b1;
        end
        sps_pkg::ST_DIV_DROP: begin
          if (dcnt == '0) begin
            mop <= sps_pkg::MOP_ADDR;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (miss) begin
      res_hit <= 1'b0;
    end

    case (state)
      sps_pkg::ST_IDLE: begin
        if (accept) begin
          tx  <= tx_in;
          ty  <= ty_in;
          tz  <= tz_in;
          lum <= stars.luminance;
          act <= stars.action;
          col <= COL_W'(stars.read_col);
          row <= ROW_W'(stars.read_row);
        end
      end
      sps_pkg::ST_MUL: begin
        prod <= mul_a * mul_b;
      end
      sps_pkg::ST_ACC: begin
        case (mop)
          sps_pkg::MOP_COL:     ncol <= NUM_W'(prod);
          sps_pkg::MOP_ROW:     nrow <= NUM_W'(prod);
          sps_pkg::MOP_COL_OFS: ncol <= ncol + (NUM_W'(prod) <<< sps_pkg::FRAC_SHIFT);
          sps_pkg::MOP_ROW_OFS: nrow <= nrow + (NUM_W'(prod) <<< sps_pkg::FRAC_SHIFT);
          sps_pkg::MOP_SQ_X:    q2 <= Q2_W'(prod);
          sps_pkg::MOP_SQ_Y:    q2 <= q2 + Q2_W'(prod);
          sps_pkg::MOP_SQ_Z:    q2 <= q2 + Q2_W'(prod);
          sps_pkg::MOP_GAIN: begin
            // gain * lum * 65535
            num  <= ($unsigned(prod) << sps_pkg::FRAC_SHIFT) - $unsigned(prod);
            rem  <= DIV_W'($unsigned(ncol));
            dsor <= DIV_W'(ty[32:0]) << (sps_pkg::FRAC_SHIFT + CB);
            quo  <= '0;
          end
          sps_pkg::MOP_ADDR: addr <= prod[ADDR_W-1:0] + ADDR_W'(col);
          default: ;
        endcase
      end
      sps_pkg::ST_DIV_COL, sps_pkg::ST_DIV_ROW, sps_pkg::ST_DIV_DROP: begin
        if (dcnt == '0) begin
          quo <= '0;
          if (state == sps_pkg::ST_DIV_COL) begin
            col  <= COL_W'(q_fin[CB-1:0]);
            rem  <= DIV_W'($unsigned(nrow));
            dsor <= DIV_W'(ty[32:0]) << (sps_pkg::FRAC_SHIFT + RB);
          end else if (state == sps_pkg::ST_DIV_ROW) begin
            row  <= ROW_W'(q_fin[RB-1:0]);
            rem  <= DIV_W'(num);
            dsor <= DIV_W'(q2) << sps_pkg::DROP_BITS;
          end else begin
            // top quotient bit set: drop saturates
            drop <= q_fin[sps_pkg::DROP_BITS] ? sps_pkg::FULL_ALPHA : q_fin[15:0];
          end
        end else begin
          if (div_ge) begin
            rem <= diff[DIV_W-1:0];
          end
          dsor <= dsor >> 1;
          quo  <= q_fin;
        end
      end
      sps_pkg::ST_WB: begin
        res_hit <= 1'b1;
        if (act == sps_pkg::ACT_READ) begin
          res_alpha <= ram_rdata;
          res_ovl   <= 1'b0;
        end else begin
          res_alpha <= new_alpha;
          res_ovl   <= (ram_rdata != sps_pkg::FULL_ALPHA);
        end
      end
      default: ;
    endcase

    if (load_out) begin
      o_hit   <= res_hit;
      o_col   <= res_hit ? col[10:0] : '0;
      o_row   <= res_hit ? row[9:0] : '0;
      o_alpha <= res_hit ? res_alpha : '0;
      o_ovl   <= res_hit && res_ovl;
    end
  end

  assign ram_we    = (state == sps_pkg::ST_CLEAR) ||
                     (state == sps_pkg::ST_WB && act == sps_pkg::ACT_SPLAT);
  assign ram_waddr = (state == sps_pkg::ST_CLEAR) ? clr_addr : addr;
  assign ram_wdata = (state == sps_pkg::ST_CLEAR) ? sps_pkg::FULL_ALPHA : new_alpha;
  assign ram_re    = (state == sps_pkg::ST_RD);

  sps_ram #(
    .WIDTH (16),
    .DEPTH (PIX)
  ) u_alpha (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign results.valid       = out_valid;
  assign results.hit         = o_hit;
  assign results.pixel_col   = o_col;
  assign results.pixel_row   = o_row;
  assign results.alpha_value = o_alpha;
  assign results.overlap     = o_ovl;

`ifndef SYNTHESIS
  a_wb_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == sps_pkg::ST_WB) |-> ($past(state) == sps_pkg::ST_RD))
    else $error("store update without a preceding read");

  a_overlap_hit: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.overlap) |-> results.hit)
    else $error("overlap flagged on a miss");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == sps_pkg::ST_DONE))
    else $error("result beat raised outside completion");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (stars.valid && stars.ready) |=> (state != sps_pkg::ST_IDLE))
    else $error("sequencer idle right after accepting a beat");
`endif

endmodule

`default_nettype wire

FILE: hdl/sps_ram.sv
`default_nettype none

module sps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
  import sps_pkg::*;

  localparam int IMG_W = 1280;
  localparam int IMG_H = 720;
  localparam longint HALF_W = IMG_W / 2;
  localparam longint HALF_H = IMG_H / 2;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        lum;
    logic [10:0]        rcol;
    logic [9:0]         rrow;
  } star_item_t;

  typedef struct packed {
    logic        hit;
    logic [10:0] col;
    logic [9:0]  row;
    logic [15:0] alpha;
    logic        overlap;
  } pixel_result_t;

  class alpha_scoreboard;
    logic signed [31:0] cam_x = CAMERA_X_RST;
    logic signed [31:0] cam_y = CAMERA_Y_RST;
    logic signed [31:0] cam_z = CAMERA_Z_RST;
    logic [19:0]        gain  = EXPOSURE_RST;
    logic [15:0]        alpha_map [int unsigned];
    pixel_result_t      expected_pixels [$];
    int                 mismatches = 0;

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_CAMERA_X: cam_x = val;
        REG_CAMERA_Y: cam_y = val;
        REG_CAMERA_Z: cam_z = val;
        REG_EXPOSURE_GAIN: gain = val[19:0];
      endcase
    endfunction

    function logic [15:0] alpha_at(int unsigned idx);
      return alpha_map.exists(idx) ? alpha_map[idx] : FULL_ALPHA;
    endfunction

    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && n < 0) q -= 1;
      return q;
    endfunction

    function logic [127:0] mag_sq(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
    endfunction

    // Projection, on-screen test and alpha update for one star beat; stored alpha for a read.
    function pixel_result_t predict_pixel(star_item_t it);
      pixel_result_t r;
      longint tx, ty, tz, den, col, row;
      logic [127:0] dist_sq, energy, drop;
      int unsigned idx;
      logic [15:0] old_a, new_a;
      r = '0;
      if (it.action == ACT_READ) begin
        if (it.rcol < IMG_W && it.rrow < IMG_H) begin
          r.hit = 1'b1;
          r.col = it.rcol;
          r.row = it.rrow;
          r.alpha = alpha_at(int'(it.rrow) * IMG_W + int'(it.rcol));
        end
        return r;
      end
      tx = longint'(it.x) - longint'(cam_x);
      ty = longint'(it.y) - longint'(cam_y);
      tz = longint'(it.z) - longint'(cam_z);
      if (ty <= 0) return r;
      den = ty * 65536;
      col = HALF_W + floor_quot((tx + tz) * ROOT2_Q16 * HALF_W, den);
      row = HALF_H + floor_quot((tz - tx) * ROOT2_Q16 * HALF_W, den);
      if (col < 0 || col >= IMG_W || row < 0 || row >= IMG_H) return r;
      dist_sq = mag_sq(tx) + mag_sq(ty) + mag_sq(tz);
      energy = 128'(gain) * 128'(it.lum) * 128'(FULL_ALPHA);
      drop = energy / dist_sq;
      if (drop > 128'(FULL_ALPHA)) drop = 128'(FULL_ALPHA);
      idx = int'(row) * IMG_W + int'(col);
      old_a = alpha_at(idx);
      new_a = (128'(old_a) > drop) ? old_a - drop[15:0] : 16'd0;
      alpha_map[idx] = new_a;
      r.hit = 1'b1;
      r.col = col[10:0];
      r.row = row[9:0];
      r.alpha = new_a;
      r.overlap = (old_a != FULL_ALPHA);
      return r;
    endfunction

    function void note_star(star_item_t it);
      expected_pixels.push_back(predict_pixel(it));
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(pixel_result_t got);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("result beat with nothing expected: col %0d row %0d", got.col, got.row);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      compare("hit", want.hit, got.hit);
      compare("pixel_col", want.col, got.col);
      compare("pixel_row", want.row, got.row);
      compare("alpha_value", want.alpha, got.alpha);
      compare("overlap", want.overlap, got.overlap);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_CAMERA_X;
  logic [31:0] cfg_data = '0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;
  int          hot_col [8] = '{0, 1279, 640, 0, 1279, 100, 1000, 640};
  int          hot_row [8] = '{0, 719, 360, 719, 0, 200, 500, 0};

  alpha_scoreboard sb = new();

  sps_in_if  stars_if ();
  sps_out_if results_if ();

  star_projection_splatter_unit #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .stars    (stars_if),
    .results  (results_if)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Star aimed at the middle of pixel (c, r) at depth ty from the current camera.
  function automatic star_item_t make_star(int c, int r, longint ty, logic [31:0] lum);
    star_item_t it;
    longint a, b, tx, tz;
    a = ((2 * longint'(c - HALF_W) + 1) * ty * 65536) / (2 * ROOT2_Q16 * HALF_W);
    b = ((2 * longint'(r - HALF_H) + 1) * ty * 65536) / (2 * ROOT2_Q16 * HALF_W);
    tz = (a + b) >>> 1;
    tx = a - tz;
    it.action = ACT_SPLAT;
    it.x = 32'(longint'(sb.cam_x) + tx);
    it.y = 32'(longint'(sb.cam_y) + ty);
    it.z = 32'(longint'(sb.cam_z) + tz);
    it.lum = lum;
    it.rcol = 11'($urandom);
    it.rrow = 10'($urandom);
    return it;
  endfunction

  function automatic star_item_t make_raw(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [31:0] lum);
    star_item_t it;
    it.action = ACT_SPLAT;
    it.x = x;
    it.y = y;
    it.z = z;
    it.lum = lum;
    it.rcol = 11'($urandom);
    it.rrow = 10'($urandom);
    return it;
  endfunction

  function automatic star_item_t make_read(int c, int r);
    star_item_t it;
    it = make_raw($urandom, $urandom, $urandom, $urandom);
    it.action = ACT_READ;
    it.rcol = c[10:0];
    it.rrow = r[9:0];
    return it;
  endfunction

  function automatic star_item_t random_item();
    int pick, kind, h, c, r;
    longint ty;
    logic [31:0] lum;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    h = $urandom_range(0, 7);
    lum = $urandom >> $urandom_range(0, 31);
    if (pick < 55) begin
      ty = 1 + longint'($urandom >> $urandom_range(0, 28));
      if (kind < 5) begin
        c = hot_col[h];
        r = hot_row[h];
      end else if (kind < 9) begin
        c = $urandom_range(0, IMG_W - 1);
        r = $urandom_range(0, IMG_H - 1);
      end else if ($urandom_range(0, 1) == 0) begin
        c = $urandom_range(0, 1) ? -1 : IMG_W;
        r = $urandom_range(0, IMG_H - 1);
      end else begin
        c = $urandom_range(0, IMG_W - 1);
        r = $urandom_range(0, 1) ? -1 : IMG_H;
      end
      return make_star(c, r, ty, lum);
    end else if (pick < 75) begin
      if (kind < 3) return make_read($urandom_range(0, 2047), $urandom_range(0, 1023));
      if (kind < 7) return make_read(hot_col[h], hot_row[h]);
      return make_read($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1));
    end
    return make_raw($urandom, $urandom, $urandom, lum);
  endfunction

  task automatic send_item(input star_item_t it);
    int gap;
    if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      stars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stars_if.valid <= 1'b1;
    stars_if.action <= it.action;
    stars_if.star_x <= it.x;
    stars_if.star_y <= it.y;
    stars_if.star_z <= it.z;
    stars_if.luminance <= it.lum;
    stars_if.read_col <= it.rcol;
    stars_if.read_row <= it.rrow;
    @(posedge clk);
    while (stars_if.ready !== 1'b1) @(posedge clk);
    sb.note_star(it);
  endtask

  task automatic wait_drained();
    stars_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_config(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [19:0] gain);
    cfg_reg_t    regs [4] = '{REG_CAMERA_X, REG_CAMERA_Y, REG_CAMERA_Z, REG_EXPOSURE_GAIN};
    logic [31:0] vals [4];
    vals = '{cx, cy, cz, {12'd0, gain}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_item(random_item());
    end
  endtask

  // Reset camera and gain; corners, edges, reads, depth limits, saturation.
  task automatic run_directed();
    send_item(make_read(0, 0));
    send_item(make_read(IMG_W - 1, IMG_H - 1));
    send_item(make_read(IMG_W, 0));
    send_item(make_read(0, IMG_H));
    send_item(make_read(2047, 1023));
    send_item(make_star(640, 360, 512000, 32'h0001_0000));
    send_item(make_star(640, 360, 512000, 32'h0001_0000));
    send_item(make_read(640, 360));
    send_item(make_star(640, 360, 1, 32'hFFFF_FFFF));
    send_item(make_star(640, 360, 0, 32'h0001_0000));
    send_item(make_star(640, 360, -5000, 32'h0001_0000));
    send_item(make_star(0, 0, 100000, 32'h0001_0000));
    send_item(make_star(IMG_W - 1, IMG_H - 1, 100000, 32'h0001_0000));
    send_item(make_star(-1, 360, 100000, 32'h0001_0000));
    send_item(make_star(IMG_W, 360, 100000, 32'h0001_0000));
    send_item(make_star(640, -1, 100000, 32'h0001_0000));
    send_item(make_star(640, IMG_H, 100000, 32'h0001_0000));
    send_item(make_star(0, 0, 100000, 32'h0));
    send_item(make_raw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send_item(make_raw(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000));
    send_item(make_raw(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
    send_item(make_read(0, 0));
    send_item(make_read(IMG_W - 1, IMG_H - 1));
  endtask

  initial begin
    int gap;
    pixel_result_t got;
    results_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) take_steady = !take_steady;
      gap = take_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (results_if.valid !== 1'b1) @(posedge clk);
      got.hit = results_if.hit;
      got.col = results_if.pixel_col;
      got.row = results_if.pixel_row;
      got.alpha = results_if.alpha_value;
      got.overlap = results_if.overlap;
      sb.check_pixel(got);
    end
  end

  initial begin
    stars_if.valid <= 1'b0;
    stars_if.action <= ACT_SPLAT;
    stars_if.star_x <= '0;
    stars_if.star_y <= '0;
    stars_if.star_z <= '0;
    stars_if.luminance <= '0;
    stars_if.read_col <= '0;
    stars_if.read_row <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(80);

    wait_drained();
    write_config(32'd0, -32'sd512000, 32'd0, 20'hFFFFF);
    run_random(80);

    // far corner camera, no gain
    wait_drained();
    write_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 20'd0);
    run_random(60);

    // nothing can sit in front of this camera
    wait_drained();
    write_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 20'($urandom));
    run_random(30);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_config($urandom_range(0, 2 ** 25) - 2 ** 24,
                   $urandom_range(0, 2 ** 25) - 2 ** 24,
                   $urandom_range(0, 2 ** 25) - 2 ** 24,
                   20'($urandom_range(0, 1048575) >> $urandom_range(0, 19)));
      run_random(90);
    end

    wait_drained();
    repeat (70) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: star_projection_splatter_unit.f
hdl/sps_pkg.sv
hdl/sps_in_if.sv
hdl/sps_out_if.sv
hdl/sps_ram.sv
hdl/star_projection_splatter_unit.sv
tb/tb_top.sv
